### src/pixel_sample_accumulator_defines.svh
// Assertion macros for the pixel sample accumulator.
// Used by pixel_sample_accumulator.sv; expects clk and rst_n in scope.
`ifndef PIXEL_SAMPLE_ACCUMULATOR_DEFINES_SVH
`define PIXEL_SAMPLE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/psa_pkg.sv
// Package for the pixel sample accumulator: sequencer states, opcodes,
// register indexes and the saturating add. No dependencies.
package psa_pkg;

    // Fixed field widths
    localparam int SUM_BITS   = 32;
    localparam int COORD_BITS = 16;
    localparam int OUT_CNT_BITS = 16;
    localparam int FRAME_BITS = 7;

    // Opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DONE
    } psa_state_t;

    // Signed add that clamps at the 32-bit limits
    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic [SUM_BITS-1:0] a,
        input logic [SUM_BITS-1:0] b
    );
        logic [SUM_BITS-1:0] s;
        logic [SUM_BITS-1:0] r;
        begin
            s = a + b;
            r = s;
            if ((a[SUM_BITS-1] == b[SUM_BITS-1]) && (s[SUM_BITS-1] != a[SUM_BITS-1]))
            begin
                r = a[SUM_BITS-1] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                  : {1'b0, {(SUM_BITS-1){1'b1}}};
            end
            return r;
        end
    endfunction

endpackage

### src/pixel_sample_accumulator.sv
// Pixel sample accumulator: per-pixel saturating color sums and counts in one memory,
// with a shared bit-serial divider for the read averages. Needs psa_pkg and the defines header.
// An add passes through the update state and an unused opcode leaves the sequencer idle; a read passes through
// update, the divider steps and the result load, where a zero-count or outside read skips the divider.
// Inputs stall until the sequencer is idle; a result waits while a stalled one holds the output register.
// Reset, clear and register writes sweep all MAX_WIDTH*MAX_HEIGHT entries (4096) stalled; reset sets 64x64.
`include "pixel_sample_accumulator_defines.svh"

module pixel_sample_accumulator
    import psa_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int COUNT_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    // Configuration
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [FRAME_BITS-1:0]          cfg_data,
    // Input channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     opcode,
    input  logic signed [COORD_BITS-1:0]   pixel_x,
    input  logic signed [COORD_BITS-1:0]   pixel_y,
    input  logic signed [SUM_BITS-1:0]     sample_red,
    input  logic signed [SUM_BITS-1:0]     sample_green,
    input  logic signed [SUM_BITS-1:0]     sample_blue,
    // Output channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [SUM_BITS-1:0]     average_red,
    output logic signed [SUM_BITS-1:0]     average_green,
    output logic signed [SUM_BITS-1:0]     average_blue,
    output logic [OUT_CNT_BITS-1:0]        sample_count,
    output logic                           in_range
);

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORD_W  = 3 * SUM_BITS + COUNT_BITS;
    localparam int SCW     = (COUNT_BITS > OUT_CNT_BITS) ? COUNT_BITS : OUT_CNT_BITS;
    localparam int BIT_W   = $clog2(SUM_BITS);
    localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [BIT_W-1:0] LAST_BIT  = BIT_W'(SUM_BITS - 1);
    localparam logic [1:0]       LAST_COMP = 2'd2;

    // Word layout: red | green | blue | count
    localparam int RED_LO   = 2 * SUM_BITS + COUNT_BITS;
    localparam int GREEN_LO = SUM_BITS + COUNT_BITS;
    localparam int BLUE_LO  = COUNT_BITS;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    psa_state_t state_reg, state_next;
    logic [FRAME_BITS-1:0] fw_reg, fh_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic                  out_valid_reg;
    logic [1:0]            comp_reg;
    logic [BIT_W-1:0]      bit_reg;

    logic                  is_read_reg;
    logic                  inside_reg;
    logic [AW-1:0]         addr_reg;
    logic [SUM_BITS-1:0]   smp_reg [3];
    logic [SUM_BITS-1:0]   sum_reg [3];
    logic [SUM_BITS-1:0]   res_reg [3];
    logic [COUNT_BITS-1:0] div_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [SUM_BITS-1:0]   dvd_reg;
    logic [OUT_CNT_BITS-1:0] cnt_out_reg;
    logic                  range_reg;

    logic [SUM_BITS-1:0]   avg_r_reg, avg_g_reg, avg_b_reg;
    logic [OUT_CNT_BITS-1:0] cnt_o_reg;
    logic                  rng_o_reg;

    // Store
    logic [WORD_W-1:0]     mem [DEPTH];
    logic [WORD_W-1:0]     rd_data_reg;

    // ------------------------------------------------------------------
    // Range check and address from the input coordinates
    // ------------------------------------------------------------------
    logic [COORD_BITS-1:0] w_lim, h_lim;
    logic                  in_inside;
    logic [AW-1:0]         in_addr;
    logic [31:0]           lin_addr;

    always_comb
    begin
        w_lim = (COORD_BITS'(fw_reg) < COORD_BITS'(MAX_WIDTH))
                ? COORD_BITS'(fw_reg) : COORD_BITS'(MAX_WIDTH);
        h_lim = (COORD_BITS'(fh_reg) < COORD_BITS'(MAX_HEIGHT))
                ? COORD_BITS'(fh_reg) : COORD_BITS'(MAX_HEIGHT);
        in_inside = !pixel_x[COORD_BITS-1] && ($unsigned(pixel_x) < w_lim) &&
                    !pixel_y[COORD_BITS-1] && ($unsigned(pixel_y) < h_lim);
        lin_addr = (32'($unsigned(pixel_y)) * 32'(MAX_WIDTH)) + 32'($unsigned(pixel_x));
        in_addr  = lin_addr[AW-1:0];
    end

    // ------------------------------------------------------------------
    // Fields of the fetched word and the divider step
    // ------------------------------------------------------------------
    logic [SUM_BITS-1:0]   rd_red, rd_green, rd_blue;
    logic [COUNT_BITS-1:0] rd_cnt;
    logic [SCW-1:0]        rd_cnt_ext;
    logic [OUT_CNT_BITS-1:0] rd_cnt_sat;
    logic [COUNT_BITS:0]   trial;
    logic                  trial_ge;
    logic [COUNT_BITS-1:0] rem_step;
    logic [SUM_BITS-1:0]   quo_step;
    logic [SUM_BITS-1:0]   quo_signed;
    logic [SUM_BITS-1:0]   cur_sum;
    logic [SUM_BITS-1:0]   next_sum;
    logic [SUM_BITS-1:0]   next_mag;
    logic [SUM_BITS-1:0]   red_mag;

    always_comb
    begin
        rd_red   = rd_data_reg[RED_LO +: SUM_BITS];
        rd_green = rd_data_reg[GREEN_LO +: SUM_BITS];
        rd_blue  = rd_data_reg[BLUE_LO +: SUM_BITS];
        rd_cnt   = rd_data_reg[COUNT_BITS-1:0];
        rd_cnt_ext = SCW'(rd_cnt);
        rd_cnt_sat = (rd_cnt_ext > SCW'({OUT_CNT_BITS{1'b1}}))
                     ? {OUT_CNT_BITS{1'b1}} : rd_cnt_ext[OUT_CNT_BITS-1:0];
        red_mag  = rd_red[SUM_BITS-1] ? (~rd_red + 1'b1) : rd_red;

        // One restoring division step: remainder stays below the divisor
        trial    = {rem_reg, dvd_reg[SUM_BITS-1]};
        trial_ge = trial >= {1'b0, div_reg};
        rem_step = trial_ge ? COUNT_BITS'(trial - {1'b0, div_reg})
                            : trial[COUNT_BITS-1:0];
        quo_step = {dvd_reg[SUM_BITS-2:0], trial_ge};

        cur_sum    = sum_reg[comp_reg];
        quo_signed = cur_sum[SUM_BITS-1] ? (~quo_step + 1'b1) : quo_step;
        next_sum   = sum_reg[(comp_reg == LAST_COMP) ? comp_reg : (comp_reg + 2'd1)];
        next_mag   = next_sum[SUM_BITS-1] ? (~next_sum + 1'b1) : next_sum;
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (opcode)
                        OP_ADD, OP_READ: state_next = ST_UPDATE;
                        OP_CLEAR:        state_next = ST_CLEAR;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_UPDATE:
            begin
                priority if (is_read_reg && inside_reg && (rd_cnt != '0))
                    state_next = ST_DIVIDE;
                else if (is_read_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_IDLE;
            end
            ST_DIVIDE:
            begin
                if ((bit_reg == LAST_BIT) && (comp_reg == LAST_COMP))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
        // A register write restarts the clear sweep of the store
        if (cfg_write)
            state_next = ST_CLEAR;
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: store write port, stall, result load
    // ------------------------------------------------------------------
    logic              mem_we;
    logic [AW-1:0]     mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic              out_load;
    logic              accept;

    always_comb
    begin
        mem_we      = 1'b0;
        mem_wr_addr = addr_reg;
        mem_wr_data = '0;
        out_load    = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we      = 1'b1;
                mem_wr_addr = clr_addr_reg;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            ST_UPDATE:
            begin
                mem_we      = !is_read_reg && inside_reg;
                mem_wr_data = {sat_add(rd_red, smp_reg[0]),
                               sat_add(rd_green, smp_reg[1]),
                               sat_add(rd_blue, smp_reg[2]),
                               (rd_cnt == '1) ? rd_cnt : (rd_cnt + 1'b1)};
            end
            ST_DIVIDE:
            begin
                mem_we = 1'b0;
            end
            ST_DONE:
            begin
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
        accept = in_valid && !in_stall;
    end

    // ------------------------------------------------------------------
    // Store: one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wr_addr] <= mem_wr_data;
        rd_data_reg <= mem[in_addr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            fw_reg        <= FRAME_BITS'(64);
            fh_reg        <= FRAME_BITS'(64);
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            comp_reg      <= '0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data;
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default:          fw_reg <= fw_reg;
                endcase
            end

            // Clear sweep address
            if (cfg_write || state_reg != ST_CLEAR)
                clr_addr_reg <= '0;
            else
                clr_addr_reg <= clr_addr_reg + 1'b1;

            // Divider step and component counters
            if (state_reg == ST_UPDATE)
            begin
                comp_reg <= '0;
                bit_reg  <= '0;
            end
            else if (state_reg == ST_DIVIDE)
            begin
                bit_reg <= bit_reg + 1'b1;
                if (bit_reg == LAST_BIT)
                    comp_reg <= comp_reg + 2'd1;
            end

            // Output transaction register
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        // Capture the transaction
        if (accept)
        begin
            is_read_reg <= (opcode == OP_READ);
            inside_reg  <= in_inside;
            addr_reg    <= in_addr;
            smp_reg[0]  <= sample_red;
            smp_reg[1]  <= sample_green;
            smp_reg[2]  <= sample_blue;
        end

        // Update state (add or read): latch sums, count and range; preset averages to zero
        if (state_reg == ST_UPDATE)
        begin
            sum_reg[0]  <= rd_red;
            sum_reg[1]  <= rd_green;
            sum_reg[2]  <= rd_blue;
            div_reg     <= rd_cnt;
            rem_reg     <= '0;
            dvd_reg     <= red_mag;
            cnt_out_reg <= inside_reg ? rd_cnt_sat : '0;
            range_reg   <= inside_reg;
            res_reg[0]  <= '0;
            res_reg[1]  <= '0;
            res_reg[2]  <= '0;
        end

        // Shared divider: one quotient bit per cycle
        if (state_reg == ST_DIVIDE)
        begin
            if (bit_reg == LAST_BIT)
            begin
                res_reg[comp_reg] <= quo_signed;
                rem_reg           <= '0;
                dvd_reg           <= next_mag;
            end
            else
            begin
                rem_reg <= rem_step;
                dvd_reg <= quo_step;
            end
        end

        // Result to the output register
        if (out_load)
        begin
            avg_r_reg <= res_reg[0];
            avg_g_reg <= res_reg[1];
            avg_b_reg <= res_reg[2];
            cnt_o_reg <= cnt_out_reg;
            rng_o_reg <= range_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign average_red   = avg_r_reg;
    assign average_green = avg_g_reg;
    assign average_blue  = avg_b_reg;
    assign sample_count  = cnt_o_reg;
    assign in_range      = rng_o_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PSA_ASSERT_NOW(a_rem_below_div, state_reg == ST_DIVIDE, rem_reg < div_reg, "bad remainder")
    `PSA_ASSERT_NOW(a_div_nonzero, state_reg == ST_DIVIDE, div_reg != '0, "divide by zero count")
    `PSA_ASSERT_NEXT(a_cfg_clears, cfg_write, state_reg == ST_CLEAR, "no clear after write")
    `PSA_ASSERT_NOW(a_out_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE, "stray result")

endmodule

### test/pixel_sample_accumulator_checker.sv
// Checker for the pixel sample accumulator: watches the config port and both
// channels, keeps its own copy of the pixel store and compares every read result.
// Depends on psa_pkg.
`timescale 1ns / 1ps

module pixel_sample_accumulator_checker
    import psa_pkg::*;
#(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int COUNT_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic                           cfg_index,
    input  logic [FRAME_BITS-1:0]          cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [1:0]                     opcode,
    input  logic signed [COORD_BITS-1:0]   pixel_x,
    input  logic signed [COORD_BITS-1:0]   pixel_y,
    input  logic signed [SUM_BITS-1:0]     sample_red,
    input  logic signed [SUM_BITS-1:0]     sample_green,
    input  logic signed [SUM_BITS-1:0]     sample_blue,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic signed [SUM_BITS-1:0]     average_red,
    input  logic signed [SUM_BITS-1:0]     average_green,
    input  logic signed [SUM_BITS-1:0]     average_blue,
    input  logic [OUT_CNT_BITS-1:0]        sample_count,
    input  logic                           in_range,
    output int                             fail_count,
    output int                             pending
);

    localparam int     STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam longint COUNT_LIMIT = (longint'(1) << COUNT_BITS) - 1;
    localparam int     PRINT_LIMIT = 100;

    // One read result as the block should present it
    typedef struct packed {
        logic signed [SUM_BITS-1:0] red;
        logic signed [SUM_BITS-1:0] green;
        logic signed [SUM_BITS-1:0] blue;
        logic [OUT_CNT_BITS-1:0]    count;
        logic                       in_frame;
    } pixel_average_t;

    // Shadow copy of the pixel store and the frame registers
    logic signed [SUM_BITS-1:0] red_sums   [STORE_DEPTH];
    logic signed [SUM_BITS-1:0] green_sums [STORE_DEPTH];
    logic signed [SUM_BITS-1:0] blue_sums  [STORE_DEPTH];
    logic [COUNT_BITS-1:0]      pixel_counts [STORE_DEPTH];
    logic [FRAME_BITS-1:0]      frame_width;
    logic [FRAME_BITS-1:0]      frame_height;

    pixel_average_t expected_averages [$];

    task automatic report_mismatch(input string detail);
        if (fail_count < PRINT_LIMIT)
            $display("%0t ns: mismatch: %s", $time, detail);
        fail_count++;
    endtask

    task automatic wipe_store();
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            red_sums[i]     = '0;
            green_sums[i]   = '0;
            blue_sums[i]    = '0;
            pixel_counts[i] = '0;
        end
    endtask

    // Signed add clamped at the 32-bit limits
    function automatic logic signed [SUM_BITS-1:0] clamped_sum(
        input logic signed [SUM_BITS-1:0] acc,
        input logic signed [SUM_BITS-1:0] sample
    );
        longint total;
        total = longint'(acc) + longint'(sample);
        if (total > longint'(32'sh7FFFFFFF))
            total = longint'(32'sh7FFFFFFF);
        if (total < -longint'(64'h80000000))
            total = -longint'(64'h80000000);
        return total[SUM_BITS-1:0];
    endfunction

    // Average truncated toward zero; count is known to be nonzero
    function automatic logic signed [SUM_BITS-1:0] mean_of(
        input logic signed [SUM_BITS-1:0] sum,
        input logic [COUNT_BITS-1:0]      cnt
    );
        longint quotient;
        quotient = longint'(sum) / longint'(cnt);
        return quotient[SUM_BITS-1:0];
    endfunction

    // Update the shadow store for one accepted transaction
    task automatic apply_transaction();
        longint         px;
        longint         py;
        longint         cols;
        longint         rows;
        bit             in_frame;
        int             slot;
        pixel_average_t want;
        px   = longint'(pixel_x);
        py   = longint'(pixel_y);
        cols = (frame_width < MAX_WIDTH) ? longint'(frame_width) : longint'(MAX_WIDTH);
        rows = (frame_height < MAX_HEIGHT) ? longint'(frame_height) : longint'(MAX_HEIGHT);
        in_frame = (px >= 0) && (px < cols) && (py >= 0) && (py < rows);
        slot = in_frame ? int'(py * MAX_WIDTH + px) : 0;
        case (opcode)
            OP_ADD:
            begin
                if (in_frame)
                begin
                    red_sums[slot]   = clamped_sum(red_sums[slot], sample_red);
                    green_sums[slot] = clamped_sum(green_sums[slot], sample_green);
                    blue_sums[slot]  = clamped_sum(blue_sums[slot], sample_blue);
                    if (longint'(pixel_counts[slot]) < COUNT_LIMIT)
                        pixel_counts[slot] = pixel_counts[slot] + 1'b1;
                end
            end
            OP_READ:
            begin
                want = '0;
                if (in_frame)
                begin
                    want.in_frame = 1'b1;
                    if (longint'(pixel_counts[slot]) > 65535)
                        want.count = '1;
                    else
                        want.count = OUT_CNT_BITS'(pixel_counts[slot]);
                    if (pixel_counts[slot] != '0)
                    begin
                        want.red   = mean_of(red_sums[slot], pixel_counts[slot]);
                        want.green = mean_of(green_sums[slot], pixel_counts[slot]);
                        want.blue  = mean_of(blue_sums[slot], pixel_counts[slot]);
                    end
                end
                expected_averages.push_back(want);
            end
            OP_CLEAR:
                wipe_store();
            default:
                ;
        endcase
    endtask

    // Compare one accepted result with the oldest expectation
    task automatic check_result();
        pixel_average_t want;
        if (expected_averages.size() == 0)
        begin
            report_mismatch("result transaction with no read outstanding");
            return;
        end
        want = expected_averages.pop_front();
        if (average_red !== want.red)
            report_mismatch($sformatf("average_red %0d, expected %0d", average_red, want.red));
        if (average_green !== want.green)
            report_mismatch($sformatf("average_green %0d, expected %0d",
                                      average_green, want.green));
        if (average_blue !== want.blue)
            report_mismatch($sformatf("average_blue %0d, expected %0d",
                                      average_blue, want.blue));
        if (sample_count !== want.count)
            report_mismatch($sformatf("sample_count %0d, expected %0d",
                                      sample_count, want.count));
        if (in_range !== want.in_frame)
            report_mismatch($sformatf("in_range %0b, expected %0b", in_range, want.in_frame));
    endtask

    // Inputs and outputs both change on the rising edge, so values read here
    // are the ones the block saw at this edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width  = 7'd64;
            frame_height = 7'd64;
            wipe_store();
            expected_averages.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // A register write also empties the store
            if (cfg_write)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    frame_width = cfg_data;
                else
                    frame_height = cfg_data;
                wipe_store();
            end
            if (in_valid && !in_stall)
                apply_transaction();
            if (out_valid && !out_stall)
                check_result();
            pending = expected_averages.size();
        end
    end

endmodule

### test/pixel_sample_accumulator_test.sv
// Testbench top for the pixel sample accumulator: clock, reset, stimulus, random
// input gaps and output stalls, and the verdict. Depends on psa_pkg, the block and
// pixel_sample_accumulator_checker.
`timescale 1ns / 1ps

module pixel_sample_accumulator_test;
    import psa_pkg::*;

    localparam int MAX_WIDTH     = 64;
    localparam int MAX_HEIGHT    = 64;
    localparam int COUNT_BITS    = 16;
    localparam int SWEEP_CYCLES  = MAX_WIDTH * MAX_HEIGHT;
    localparam int SETTLE_CYCLES = SWEEP_CYCLES + 104;
    localparam int IDLE_LIMIT    = 40000;
    localparam int PHASE_ITEMS   = 240;
    localparam int SAT_ADDS      = 20;

    localparam logic [1:0]              OP_UNUSED = 2'd3;
    localparam logic signed [SUM_BITS-1:0] SUM_MAX = 32'sh7FFFFFFF;
    localparam logic signed [SUM_BITS-1:0] SUM_MIN = 32'sh80000000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_write = 1'b0;
    logic                         cfg_index = REG_FRAME_WIDTH;
    logic [FRAME_BITS-1:0]        cfg_data = '0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [1:0]                   opcode = OP_ADD;
    logic signed [COORD_BITS-1:0] pixel_x = '0;
    logic signed [COORD_BITS-1:0] pixel_y = '0;
    logic signed [SUM_BITS-1:0]   sample_red = '0;
    logic signed [SUM_BITS-1:0]   sample_green = '0;
    logic signed [SUM_BITS-1:0]   sample_blue = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic signed [SUM_BITS-1:0]   average_red;
    logic signed [SUM_BITS-1:0]   average_green;
    logic signed [SUM_BITS-1:0]   average_blue;
    logic [OUT_CNT_BITS-1:0]      sample_count;
    logic                         in_range;

    int mismatches;
    int pending;
    int idle_cycles = 0;
    int stall_run = 0;
    bit pace_sender = 1'b1;
    bit pace_sink = 1'b1;
    int frame_cols = MAX_WIDTH;
    int frame_rows = MAX_HEIGHT;

    always #5 clk = ~clk;

    pixel_sample_accumulator #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .sample_red    (sample_red),
        .sample_green  (sample_green),
        .sample_blue   (sample_blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average_red   (average_red),
        .average_green (average_green),
        .average_blue  (average_blue),
        .sample_count  (sample_count),
        .in_range      (in_range)
    );

    pixel_sample_accumulator_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .sample_red    (sample_red),
        .sample_green  (sample_green),
        .sample_blue   (sample_blue),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average_red   (average_red),
        .average_green (average_green),
        .average_blue  (average_blue),
        .sample_count  (sample_count),
        .in_range      (in_range),
        .fail_count    (mismatches),
        .pending       (pending)
    );

    // Result side back-pressure: runs of stall and free cycles
    always @(posedge clk)
    begin
        if (!pace_sink)
        begin
            out_stall <= 1'b0;
            stall_run = 0;
        end
        else if (stall_run > 0)
            stall_run--;
        else if ($urandom_range(0, 99) < 30)
        begin
            out_stall <= 1'b1;
            if ($urandom_range(0, 99) < 80)
                stall_run = $urandom_range(0, 2);
            else if ($urandom_range(0, 99) < 75)
                stall_run = $urandom_range(3, 12);
            else
                stall_run = $urandom_range(20, 60);
        end
        else
        begin
            out_stall <= 1'b0;
            stall_run = $urandom_range(0, 20);
        end
    end

    // Watchdog: too long with no transaction on any port ends the run
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("pixel_sample_accumulator test failed");
                $finish;
            end
        end
    end

    function automatic int sender_gap();
        int r;
        if (!pace_sender)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    // Mostly a few hot pixels near the origin, plus edges and outside values
    function automatic logic signed [COORD_BITS-1:0] pick_coord(input int lim);
        int                           r;
        logic signed [COORD_BITS-1:0] coord;
        r = $urandom_range(0, 99);
        if (r < 55 && lim > 0)
            coord = COORD_BITS'($urandom_range(0, (lim < 4 ? lim : 4) - 1));
        else if (r < 75 && lim > 0)
            coord = COORD_BITS'($urandom_range(0, lim - 1));
        else if (r < 82)
            coord = COORD_BITS'(lim - 1);
        else if (r < 90)
            coord = COORD_BITS'(lim);
        else if (r < 94)
            coord = COORD_BITS'(-1);
        else
            coord = COORD_BITS'($urandom);
        return coord;
    endfunction

    function automatic logic signed [SUM_BITS-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return int'($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
        if (r < 75)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return SUM_MAX;
            1:       return SUM_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // Present one transaction and hold it until accepted
    task automatic send_item(
        input logic [1:0]                   op,
        input logic signed [COORD_BITS-1:0] x,
        input logic signed [COORD_BITS-1:0] y,
        input logic signed [SUM_BITS-1:0]   r,
        input logic signed [SUM_BITS-1:0]   g,
        input logic signed [SUM_BITS-1:0]   b
    );
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        pixel_x      <= x;
        pixel_y      <= y;
        sample_red   <= r;
        sample_green <= g;
        sample_blue  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop sending and wait until every read result has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [FRAME_BITS-1:0] value);
        wait_drained();
        // a clear may still be sweeping the store
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            frame_cols = (value < MAX_WIDTH) ? value : MAX_WIDTH;
        else
            frame_rows = (value < MAX_HEIGHT) ? value : MAX_HEIGHT;
    endtask

    task automatic set_frame(input logic [FRAME_BITS-1:0] cols, input logic [FRAME_BITS-1:0] rows);
        write_register(REG_FRAME_WIDTH, cols);
        write_register(REG_FRAME_HEIGHT, rows);
    endtask

    // Random mix of adds and reads, with rare clears and unused opcodes
    task automatic run_random(input int count);
        int         sent;
        int         r;
        logic [1:0] op;
        sent = 0;
        while (sent < count)
        begin
            if (sent % 50 == 0)
            begin
                pace_sender = ($urandom_range(0, 3) != 0);
                pace_sink   = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 60)
                op = OP_ADD;
            else if (r < 87)
                op = OP_READ;
            else if (r < 88)
                op = OP_CLEAR;
            else if (r < 92)
                op = OP_UNUSED;
            else
                op = OP_ADD;
            send_item(op, pick_coord(frame_cols), pick_coord(frame_rows),
                      pick_sample(), pick_sample(), pick_sample());
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pixel, rounding, sum saturation, frame edges
        send_item(OP_READ, 0, 0, 0, 0, 0);
        send_item(OP_ADD, 0, 0, 7, -7, SUM_MAX);
        send_item(OP_ADD, 0, 0, 0, 0, SUM_MAX);
        send_item(OP_READ, 0, 0, 0, 0, 0);
        send_item(OP_ADD, 63, 63, SUM_MIN, SUM_MIN, 1);
        send_item(OP_ADD, 63, 63, SUM_MIN, -1, SUM_MAX);
        send_item(OP_READ, 63, 63, 0, 0, 0);
        send_item(OP_ADD, 64, 0, 5, 5, 5);
        send_item(OP_ADD, 0, 64, 5, 5, 5);
        send_item(OP_ADD, -1, 0, 5, 5, 5);
        send_item(OP_ADD, -32768, 32767, 5, 5, 5);
        send_item(OP_READ, 64, 0, 0, 0, 0);
        send_item(OP_READ, -32768, -32768, SUM_MIN, SUM_MIN, SUM_MIN);
        send_item(OP_READ, 32767, 32767, SUM_MAX, SUM_MAX, SUM_MAX);
        send_item(OP_UNUSED, 0, 0, SUM_MAX, SUM_MIN, -1);
        send_item(OP_READ, 0, 0, 0, 0, 0);
        send_item(OP_READ, 63, 0, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(OP_READ, 0, 0, 0, 0, 0);
        send_item(OP_READ, 63, 63, 0, 0, 0);
        send_item(OP_ADD, 5, 5, -5, 5, -1);
        send_item(OP_ADD, 5, 5, 0, 0, 0);
        send_item(OP_READ, 5, 5, 0, 0, 0);

        // Full frame, with one pause until all reads have returned
        run_random(PHASE_ITEMS / 2);
        wait_drained();
        run_random(PHASE_ITEMS - PHASE_ITEMS / 2);

        // Back-to-back adds to one pixel, then adds and reads interleaved
        pace_sender = 1'b0;
        pace_sink   = 1'b0;
        for (int i = 0; i < SAT_ADDS; i++)
            send_item(OP_ADD, 2, 3, pick_sample(), pick_sample(), pick_sample());
        for (int i = 0; i < 12; i++)
        begin
            send_item(OP_ADD, 2, 3, pick_sample(), pick_sample(), pick_sample());
            send_item(OP_READ, 2, 3, 0, 0, 0);
        end

        // Frame settings: smallest, zero width, clamped, odd, full again
        set_frame(1, 1);
        run_random(PHASE_ITEMS);
        set_frame(0, 5);
        run_random(PHASE_ITEMS);
        set_frame(127, 100);
        run_random(PHASE_ITEMS);
        set_frame(37, 23);
        run_random(PHASE_ITEMS);
        set_frame(64, 64);
        run_random(PHASE_ITEMS);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("pixel_sample_accumulator test passed");
        else
            $display("pixel_sample_accumulator test failed");
        $finish;
    end

endmodule
